@@ sv/wls_pkg.sv @@
// Shared types and constants for the WAV LSB steganography stream unit.
package wls_pkg;

    // Mode register values.
    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    // One classified file word as it travels from the parser to the LSB unit.
    typedef struct packed {
        logic [7:0]  file_byte;
        logic        message_bit;
        logic        end_of_file;
        logic [1:0]  region;
        logic        audio;       // byte belongs to the audio payload
        logic        first;       // first audio byte of the data chunk
        logic [28:0] ext_load;    // whole bytes to extract, valid with first
        logic [2:0]  status;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [15:0] bit_depth;
    } wls_item_t;

    // One finished result word held in the output register.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  region;
        logic        bit_consumed;
        logic [7:0]  extracted_byte;
        logic        extracted_valid;
        logic [2:0]  status;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [15:0] bit_depth;
        logic        final_res;
    } wls_result_t;

endpackage

@@ sv/wls_front.sv @@
// Header and chunk parser: classifies each file byte and tracks the status.
module wls_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mode,
    input  logic [28:0]         message_bytes,
    input  logic                accept,
    input  logic [7:0]          file_byte,
    input  logic                message_bit,
    input  logic                end_of_file,
    output wls_pkg::wls_item_t  item
);
    import wls_pkg::*;

    // Parser phases.
    localparam logic [2:0] PH_RIFF = 3'd0;
    localparam logic [2:0] PH_CHDR = 3'd1;
    localparam logic [2:0] PH_BODY = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_TAIL = 3'd4;
    localparam logic [2:0] PH_STOP = 3'd5;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SMALL = 3'd1;
    localparam logic [2:0] ST_NOT_RIFF  = 3'd2;
    localparam logic [2:0] ST_NOT_WAVE  = 3'd3;
    localparam logic [2:0] ST_BAD_FMT   = 3'd4;
    localparam logic [2:0] ST_NOT_PCM   = 3'd5;
    localparam logic [2:0] ST_MISSING   = 3'd6;
    localparam logic [2:0] ST_CAPACITY  = 3'd7;

    // Region codes.
    localparam logic [1:0] RG_HEADER = 2'd0;
    localparam logic [1:0] RG_AUDIO  = 2'd1;
    localparam logic [1:0] RG_TAIL   = 2'd2;

    // Chunk tags as little-endian words.
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;
    localparam logic [15:0] FMT_PCM     = 16'd1;

    // Expected bytes of the RIFF and WAVE tags.
    function automatic logic [7:0] riff_char(input logic [1:0] k);
        logic [7:0] c;
        case (k)
            2'd0:    c = 8'h52;
            2'd1:    c = 8'h49;
            default: c = 8'h46;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] wave_char(input logic [1:0] k);
        logic [7:0] c;
        case (k)
            2'd0:    c = 8'h57;
            2'd1:    c = 8'h41;
            2'd2:    c = 8'h56;
            default: c = 8'h45;
        endcase
        return c;
    endfunction

    // Replace byte k of a 32-bit little-endian word.
    function automatic logic [31:0] put_byte(input logic [31:0] v, input logic [1:0] k,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = v;
        case (k)
            2'd0:    r[7:0]   = b;
            2'd1:    r[15:8]  = b;
            2'd2:    r[23:16] = b;
            default: r[31:24] = b;
        endcase
        return r;
    endfunction

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  header_pos_reg, header_pos_next;
    logic [1:0]  tags_ok_reg, tags_ok_next;
    logic [31:0] chunk_tag_reg, chunk_tag_next;
    logic [31:0] chunk_length_reg, chunk_length_next;
    logic [31:0] chunk_offset_reg, chunk_offset_next;
    logic [15:0] format_code_reg, format_code_next;
    logic [15:0] channel_count_reg, channel_count_next;
    logic [31:0] rate_value_reg, rate_value_next;
    logic [15:0] depth_value_reg, depth_value_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic [31:0] audio_left_reg, audio_left_next;
    logic        data_first_reg, data_first_next;
    logic [2:0]  error_code_reg, error_code_next;

    logic [3:0]  rpos;
    logic [2:0]  cpos;
    logic [31:0] word_tmp;
    logic        hdr_done;
    logic        chunk_end;

    // Next-state logic for one accepted byte.
    always_comb
    begin
        phase_next         = phase_reg;
        header_pos_next    = header_pos_reg;
        tags_ok_next       = tags_ok_reg;
        chunk_tag_next     = chunk_tag_reg;
        chunk_length_next  = chunk_length_reg;
        chunk_offset_next  = chunk_offset_reg;
        format_code_next   = format_code_reg;
        channel_count_next = channel_count_reg;
        rate_value_next    = rate_value_reg;
        depth_value_next   = depth_value_reg;
        fmt_seen_next      = fmt_seen_reg;
        audio_left_next    = audio_left_reg;
        data_first_next    = data_first_reg;
        error_code_next    = error_code_reg;
        rpos               = header_pos_reg;
        cpos               = header_pos_reg[2:0];
        word_tmp           = '0;
        hdr_done           = 1'b0;
        chunk_end          = 1'b0;

        item.file_byte   = file_byte;
        item.message_bit = message_bit;
        item.end_of_file = end_of_file;
        item.audio       = 1'b0;
        item.first       = data_first_reg;
        item.ext_load    = chunk_length_reg[31:3];
        if (phase_reg == PH_DATA)
            item.region = RG_AUDIO;
        else if (phase_reg == PH_TAIL)
            item.region = RG_TAIL;
        else
            item.region = RG_HEADER;

        unique case (phase_reg)
            PH_RIFF:
            begin
                if (rpos < 4'd4 && file_byte != riff_char(rpos[1:0]))
                    tags_ok_next[0] = 1'b0;
                if (rpos >= 4'd8 && rpos < 4'd12 && file_byte != wave_char(rpos[1:0]))
                    tags_ok_next[1] = 1'b0;
                if (rpos >= 4'd11)
                begin
                    header_pos_next = '0;
                    if (!tags_ok_next[0])
                    begin
                        error_code_next = ST_NOT_RIFF;
                        phase_next      = PH_STOP;
                    end
                    else if (!tags_ok_next[1])
                    begin
                        error_code_next = ST_NOT_WAVE;
                        phase_next      = PH_STOP;
                    end
                    else
                        phase_next = PH_CHDR;
                end
                else
                    header_pos_next = rpos + 4'd1;
            end
            PH_CHDR:
            begin
                if (!cpos[2])
                begin
                    word_tmp       = (cpos == 3'd0) ? 32'd0 : chunk_tag_reg;
                    chunk_tag_next = put_byte(word_tmp, cpos[1:0], file_byte);
                end
                else
                begin
                    word_tmp          = (cpos == 3'd4) ? 32'd0 : chunk_length_reg;
                    chunk_length_next = put_byte(word_tmp, cpos[1:0], file_byte);
                end
                if (cpos == 3'd7)
                    hdr_done = 1'b1;
                else
                    header_pos_next = {1'b0, cpos + 3'd1};
            end
            PH_BODY:
            begin
                if (chunk_tag_reg == TAG_FMT)
                begin
                    if (chunk_offset_reg < 32'd2)
                        format_code_next = put_byte({16'd0, format_code_reg},
                            {1'b0, chunk_offset_reg[0]}, file_byte)[15:0];
                    else if (chunk_offset_reg < 32'd4)
                        channel_count_next = put_byte({16'd0, channel_count_reg},
                            {1'b0, chunk_offset_reg[0]}, file_byte)[15:0];
                    else if (chunk_offset_reg < 32'd8)
                        rate_value_next = put_byte(rate_value_reg,
                            chunk_offset_reg[1:0], file_byte);
                    else if (chunk_offset_reg == 32'd14 || chunk_offset_reg == 32'd15)
                        depth_value_next = put_byte({16'd0, depth_value_reg},
                            {1'b0, chunk_offset_reg[0]}, file_byte)[15:0];
                end
                chunk_offset_next = chunk_offset_reg + 32'd1;
                if (chunk_offset_next >= chunk_length_reg)
                    chunk_end = 1'b1;
            end
            PH_DATA:
            begin
                item.audio      = 1'b1;
                data_first_next = 1'b0;
                audio_left_next = audio_left_reg - 32'd1;
                if (audio_left_next == 32'd0)
                    phase_next = PH_TAIL;
            end
            default:
            begin
                // Tail and stopped phases pass bytes untouched.
            end
        endcase

        // Chunk header complete: decide where the chunk goes.
        if (hdr_done)
        begin
            header_pos_next   = '0;
            chunk_offset_next = '0;
            if (chunk_tag_next == TAG_DATA)
            begin
                if (!fmt_seen_reg)
                begin
                    error_code_next = ST_MISSING;
                    phase_next      = PH_STOP;
                end
                else if (mode == MODE_EMBED && message_bytes > chunk_length_next[31:3])
                begin
                    error_code_next = ST_CAPACITY;
                    phase_next      = PH_STOP;
                end
                else
                begin
                    audio_left_next = chunk_length_next;
                    data_first_next = 1'b1;
                    phase_next      = (chunk_length_next == 32'd0) ? PH_TAIL : PH_DATA;
                end
            end
            else if (chunk_length_next == 32'd0)
                chunk_end = 1'b1;
            else
                phase_next = PH_BODY;
        end

        // End of a non-data chunk: judge the format chunk.
        if (chunk_end)
        begin
            phase_next      = PH_CHDR;
            header_pos_next = '0;
            if (chunk_tag_next == TAG_FMT)
            begin
                if (chunk_length_next < FMT_MIN_LEN)
                begin
                    error_code_next = ST_BAD_FMT;
                    phase_next      = PH_STOP;
                end
                else if (format_code_next != FMT_PCM)
                begin
                    error_code_next = ST_NOT_PCM;
                    phase_next      = PH_STOP;
                end
                else
                    fmt_seen_next = 1'b1;
            end
        end

        // A file that ends early reports what was missing.
        if (end_of_file && error_code_next == ST_OK)
        begin
            if (phase_next == PH_RIFF)
            begin
                error_code_next = ST_TOO_SMALL;
                phase_next      = PH_STOP;
            end
            else if (phase_next == PH_CHDR || phase_next == PH_BODY || phase_next == PH_DATA)
            begin
                error_code_next = ST_MISSING;
                phase_next      = PH_STOP;
            end
        end

        item.status      = error_code_next;
        item.channels    = channel_count_next;
        item.sample_rate = rate_value_next;
        item.bit_depth   = depth_value_next;

        // The last byte of a file returns the parser to its start.
        if (end_of_file)
        begin
            phase_next         = PH_RIFF;
            header_pos_next    = '0;
            tags_ok_next       = 2'b11;
            chunk_tag_next     = '0;
            chunk_length_next  = '0;
            chunk_offset_next  = '0;
            format_code_next   = '0;
            channel_count_next = '0;
            rate_value_next    = '0;
            depth_value_next   = '0;
            fmt_seen_next      = 1'b0;
            audio_left_next    = '0;
            data_first_next    = 1'b0;
            error_code_next    = ST_OK;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_RIFF;
            header_pos_reg    <= '0;
            tags_ok_reg       <= 2'b11;
            chunk_tag_reg     <= '0;
            chunk_length_reg  <= '0;
            chunk_offset_reg  <= '0;
            format_code_reg   <= '0;
            channel_count_reg <= '0;
            rate_value_reg    <= '0;
            depth_value_reg   <= '0;
            fmt_seen_reg      <= 1'b0;
            audio_left_reg    <= '0;
            data_first_reg    <= 1'b0;
            error_code_reg    <= ST_OK;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            header_pos_reg    <= header_pos_next;
            tags_ok_reg       <= tags_ok_next;
            chunk_tag_reg     <= chunk_tag_next;
            chunk_length_reg  <= chunk_length_next;
            chunk_offset_reg  <= chunk_offset_next;
            format_code_reg   <= format_code_next;
            channel_count_reg <= channel_count_next;
            rate_value_reg    <= rate_value_next;
            depth_value_reg   <= depth_value_next;
            fmt_seen_reg      <= fmt_seen_next;
            audio_left_reg    <= audio_left_next;
            data_first_reg    <= data_first_next;
            error_code_reg    <= error_code_next;
        end
    end

    // A held error survives until the file ends.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (error_code_reg != ST_OK && !(accept && end_of_file))
            |=> error_code_reg == $past(error_code_reg))
        else $error("error code changed before end of file");

    // Audio and tail phases are reached only without an error.
    a_no_audio_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA || phase_reg == PH_TAIL) |-> error_code_reg == ST_OK)
        else $error("audio phase with an error held");

    // Stopped phase always carries an error.
    a_stop_has_error: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_STOP |-> error_code_reg != ST_OK)
        else $error("stopped phase without an error");

endmodule

@@ sv/wls_queue.sv @@
// Short queue between the parser and the LSB unit.
module wls_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wls_pkg::wls_item_t  push_item,
    output logic                ready,
    input  logic                pop,
    output logic                valid,
    output wls_pkg::wls_item_t  head
);
    import wls_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    wls_item_t       mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign ready = count_reg < CW'(DEPTH);
    assign valid = count_reg != '0;
    assign head  = mem[rd_ptr_reg];

    // Storage writes.
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    // The queue never overflows or underflows.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push |-> ready) and (pop |-> valid))
        else $error("queue pushed when full or popped when empty");

endmodule

@@ sv/wls_back.sv @@
// LSB unit: embeds or extracts message bits and holds the result word.
module wls_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 mode,
    input  logic [28:0]          message_bytes,
    input  logic                 head_valid,
    input  wls_pkg::wls_item_t   head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wls_pkg::wls_result_t result
);
    import wls_pkg::*;

    logic [31:0] bits_done_reg, bits_done_next;
    logic [7:0]  pack_shift_reg, pack_shift_next;
    logic [2:0]  pack_count_reg, pack_count_next;
    logic [28:0] extract_left_reg, extract_left_next;
    logic        out_valid_reg;
    wls_result_t result_reg;
    wls_result_t res;
    logic [31:0] bit_limit;

    assign bit_limit = {message_bytes, 3'b000};
    assign pop       = head_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // Embed or extract on one audio byte.
    always_comb
    begin
        bits_done_next    = bits_done_reg;
        pack_shift_next   = head.first ? 8'd0 : pack_shift_reg;
        pack_count_next   = head.first ? 3'd0 : pack_count_reg;
        extract_left_next = head.first ? head.ext_load : extract_left_reg;

        res.out_byte        = head.file_byte;
        res.region          = head.region;
        res.bit_consumed    = 1'b0;
        res.extracted_byte  = 8'd0;
        res.extracted_valid = 1'b0;
        res.status          = head.status;
        res.channels        = head.channels;
        res.sample_rate     = head.sample_rate;
        res.bit_depth       = head.bit_depth;
        res.final_res       = head.end_of_file;

        if (head.audio)
        begin
            if (mode == MODE_EMBED)
            begin
                if (bits_done_reg < bit_limit)
                begin
                    res.out_byte     = {head.file_byte[7:1], head.message_bit};
                    res.bit_consumed = 1'b1;
                    bits_done_next   = bits_done_reg + 32'd1;
                end
            end
            else if (extract_left_next != 29'd0)
            begin
                pack_shift_next = {pack_shift_next[6:0], head.file_byte[0]};
                if (pack_count_next == 3'd7)
                begin
                    res.extracted_byte  = pack_shift_next;
                    res.extracted_valid = 1'b1;
                    pack_count_next     = 3'd0;
                    pack_shift_next     = 8'd0;
                    extract_left_next   = extract_left_next - 29'd1;
                end
                else
                    pack_count_next = pack_count_next + 3'd1;
            end
        end

        // A new file starts from clean counters.
        if (head.end_of_file)
        begin
            bits_done_next    = '0;
            pack_shift_next   = '0;
            pack_count_next   = '0;
            extract_left_next = '0;
        end
    end

    // Bit counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_done_reg    <= '0;
            pack_shift_reg   <= '0;
            pack_count_reg   <= '0;
            extract_left_reg <= '0;
        end
        else if (pop)
        begin
            bits_done_reg    <= bits_done_next;
            pack_shift_reg   <= pack_shift_next;
            pack_count_reg   <= pack_count_next;
            extract_left_reg <= extract_left_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (pop)
            result_reg <= res;
    end

    // A word never both embeds and extracts.
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(result_reg.bit_consumed && result_reg.extracted_valid))
        else $error("embed and extract in the same word");

    // Embedding stops at the message length.
    a_bit_limit: assert property (@(posedge clk) disable iff (!rst_n)
        bits_done_reg <= bit_limit || bits_done_reg == 32'd0)
        else $error("more bits embedded than the message holds");

endmodule

@@ sv/wav_lsb_stego_stream_unit.sv @@
// Top level of the WAV LSB steganography stream unit.
//
//  Channel   Direction  Handshake              Payload
//  s_axis    in         s_axis_tvalid/tready   tdata: file_byte, message_bit; tlast: end_of_file
//  m_axis    out        m_axis_tvalid/tready   tdata: result fields; tuser: region;
//                                              tlast: final_res
//  cfg       in         cfg_we                 cfg_index, cfg_data
//
// One file byte is taken every cycle while the queue has room; a result word passes from the
// parser into the queue, then through the LSB unit into the output register.
// The parser state advances on each accepted byte, so that update loop sets
// the rate. A two-entry queue lets input continue while m_axis stalls.
// Reset clears the parser, counters, queue and registers; no clearing pass.
module wav_lsb_stego_stream_unit
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // [7:0] file_byte, [8] message_bit, rest zero
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [87:0]  m_axis_tdata,   // [7:0] out_byte, [8] bit_consumed,
                                         // [16:9] extracted_byte, [17] extracted_valid,
                                         // [20:18] status, [36:21] channels,
                                         // [68:37] sample_rate, [84:69] bit_depth, rest zero
    output logic [1:0]   m_axis_tuser,   // [1:0] region
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [28:0]  cfg_data
);
    import wls_pkg::*;

    localparam logic REG_MODE    = 1'b0;
    localparam logic REG_MSG_LEN = 1'b1;

    logic        mode_reg;
    logic [28:0] message_bytes_reg;
    logic        accept;
    logic        q_ready;
    logic        q_valid;
    logic        q_pop;
    wls_item_t   front_item;
    wls_item_t   q_head;
    wls_result_t result;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_EMBED;
            message_bytes_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:    mode_reg          <= cfg_data[0];
                REG_MSG_LEN: message_bytes_reg <= cfg_data;
                default:     mode_reg          <= mode_reg;
            endcase
        end
    end

    assign s_axis_tready = q_ready;
    assign accept        = s_axis_tvalid && q_ready;

    wls_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode_reg),
        .message_bytes (message_bytes_reg),
        .accept        (accept),
        .file_byte     (s_axis_tdata[7:0]),
        .message_bit   (s_axis_tdata[8]),
        .end_of_file   (s_axis_tlast),
        .item          (front_item)
    );

    wls_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    wls_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode_reg),
        .message_bytes (message_bytes_reg),
        .head_valid    (q_valid),
        .head          (q_head),
        .pop           (q_pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .result        (result)
    );

    // Pack the result word.
    assign m_axis_tdata = {3'b000, result.bit_depth, result.sample_rate, result.channels,
                           result.status, result.extracted_valid, result.extracted_byte,
                           result.bit_consumed, result.out_byte};
    assign m_axis_tuser = result.region;
    assign m_axis_tlast = result.final_res;

endmodule
